FILE: design/conv3_pkg.sv
package conv3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WREG_W     = 12;
  localparam int ROW_W      = 16;
  localparam int WCMP_W     = (COL_W + 1 > WREG_W) ? COL_W + 1 : WREG_W;
  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int OUT_COL_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 12;
  localparam int RECIP9     = 7282;
  localparam int RECIP9_W   = 13;
  localparam int RECIP9_SH  = 16;
  localparam int WORD_W     = 2 * PIX_W;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_MEAN  = 1'b0,
    MODE_SHARP = 1'b1
  } mode_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit;
    logic             last;
  } pos_t;

endpackage

FILE: design/conv3_ram.sv
module conv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/conv3_ctrl.sv
module conv3_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             accept,
  output conv3_pkg::mode_t                 mode,
  output conv3_pkg::pos_t                  pos
);

  conv3_pkg::mode_t                 mode_r;
  logic [conv3_pkg::WREG_W-1:0]     width_r;
  logic [conv3_pkg::ROW_W-1:0]      height_r;
  logic [conv3_pkg::COL_W-1:0]      col_r;
  logic [conv3_pkg::COL_W-1:0]      col_nxt;
  logic [conv3_pkg::ROW_W-1:0]      row_r;
  logic [conv3_pkg::ROW_W-1:0]      row_nxt;
  logic [conv3_pkg::WCMP_W-1:0]     wlast;
  logic [conv3_pkg::ROW_W-1:0]      hlast;
  logic                             end_row;
  logic                             end_img;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= conv3_pkg::MODE_MEAN;
      width_r  <= conv3_pkg::WREG_W'(2048);
      height_r <= conv3_pkg::ROW_W'(2048);
    end else if (cfg_wr) begin
      unique case (conv3_pkg::cfg_idx_t'(cfg_index))
        conv3_pkg::CFG_MODE:   mode_r   <= conv3_pkg::mode_t'(cfg_data[0]);
        conv3_pkg::CFG_WIDTH:  width_r  <= cfg_data[conv3_pkg::WREG_W-1:0];
        conv3_pkg::CFG_HEIGHT: height_r <= cfg_data[conv3_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // last column and row after clamping the configured size
  always_comb begin
    if (width_r < conv3_pkg::WREG_W'(3)) begin
      wlast = conv3_pkg::WCMP_W'(2);
    end else if (conv3_pkg::WCMP_W'(width_r) > conv3_pkg::WCMP_W'(conv3_pkg::MAX_WIDTH)) begin
      wlast = conv3_pkg::WCMP_W'(conv3_pkg::MAX_WIDTH - 1);
    end else begin
      wlast = conv3_pkg::WCMP_W'(width_r) - conv3_pkg::WCMP_W'(1);
    end
    if (height_r < conv3_pkg::ROW_W'(3)) begin
      hlast = conv3_pkg::ROW_W'(2);
    end else begin
      hlast = height_r - conv3_pkg::ROW_W'(1);
    end
  end

  assign end_row = conv3_pkg::WCMP_W'(col_r) >= wlast;
  assign end_img = end_row && (row_r >= hlast);

  always_comb begin
    if (end_row) begin
      col_nxt = '0;
      row_nxt = end_img ? '0 : row_r + conv3_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_r + conv3_pkg::COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign mode     = mode_r;
  assign pos.col  = col_r;
  assign pos.row  = row_r;
  assign pos.emit = (row_r >= conv3_pkg::ROW_W'(2)) && (col_r >= conv3_pkg::COL_W'(2));
  assign pos.last = end_img;

  a_wrap_to_origin: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_img |=> (col_r == '0) && (row_r == '0))
    else $error("counters did not wrap at end of image");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !end_row |=> col_r == $past(col_r) + conv3_pkg::COL_W'(1))
    else $error("column counter skipped");

endmodule

FILE: design/conv3_window.sv
module conv3_window (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  conv3_pkg::pix_t  top,
  input  conv3_pkg::pix_t  mid,
  input  conv3_pkg::pix_t  px,
  input  conv3_pkg::mode_t mode,
  output conv3_pkg::pix_t  value
);

  conv3_pkg::win_t                                win_r;
  conv3_pkg::win_t                                win_nxt;
  logic [conv3_pkg::SUM_W-1:0]                    sum;
  logic [conv3_pkg::SUM_W+conv3_pkg::RECIP9_W-1:0] prod;
  conv3_pkg::pix_t                                mean;
  logic [conv3_pkg::PIX_W+2:0]                    c5;
  logic [conv3_pkg::PIX_W+1:0]                    nb;
  logic signed [conv3_pkg::PIX_W+3:0]             diff;
  conv3_pkg::pix_t                                sharp;

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

  // mean: sum of nine times reciprocal of nine, exact for sums up to 2295
  always_comb begin
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      sum = sum + conv3_pkg::SUM_W'(win_nxt[k]);
    end
  end

  assign prod = (conv3_pkg::SUM_W + conv3_pkg::RECIP9_W)'(sum)
              * (conv3_pkg::SUM_W + conv3_pkg::RECIP9_W)'(conv3_pkg::RECIP9);
  assign mean = prod[conv3_pkg::RECIP9_SH +: conv3_pkg::PIX_W];

  always_comb begin
    c5   = {1'b0, win_nxt[4], 2'b00} + (conv3_pkg::PIX_W + 3)'(win_nxt[4]);
    nb   = (conv3_pkg::PIX_W + 2)'(win_nxt[1]) + (conv3_pkg::PIX_W + 2)'(win_nxt[3])
         + (conv3_pkg::PIX_W + 2)'(win_nxt[5]) + (conv3_pkg::PIX_W + 2)'(win_nxt[7]);
    diff = $signed({1'b0, c5}) - $signed({2'b00, nb});
    if (diff < 0) begin
      sharp = '0;
    end else if (diff > $signed((conv3_pkg::PIX_W + 4)'(conv3_pkg::PIX_MAX))) begin
      sharp = conv3_pkg::PIX_W'(conv3_pkg::PIX_MAX);
    end else begin
      sharp = diff[conv3_pkg::PIX_W-1:0];
    end
  end

  assign value = (mode == conv3_pkg::MODE_SHARP) ? sharp : mean;

endmodule

FILE: design/conv3x3_smooth_sharpen_filter.sv
// the item completing a window is registered in stage 1, its result in the output stage
// one item per cycle unless the output stalls; one line store read and write per item
// the line store is a single 16-bit wide ram holding the two previous rows side by side
// reset: counters, window, mode, width and height return to their defaults
// the line store is not cleared and needs no clearing pass
module conv3x3_smooth_sharpen_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_pixel_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_pixel_out,
  output logic [10:0]                      out_centre_col,
  output logic [15:0]                      out_centre_row,
  output logic                             out_last_of_image,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                              in_accept;
  conv3_pkg::mode_t                  mode;
  conv3_pkg::pos_t                   pos;
  logic [conv3_pkg::WORD_W-1:0]      rd_word;
  logic                              s1_valid_r;
  conv3_pkg::pos_t                   s1_pos_r;
  conv3_pkg::pix_t                   s1_px_r;
  logic                              s1_adv;
  logic                              load_out;
  conv3_pkg::pix_t                   value;
  logic [conv3_pkg::COL_W-1:0]       cm1;
  logic                              out_valid_r;
  conv3_pkg::pix_t                   out_pixel_r;
  logic [conv3_pkg::OUT_COL_W-1:0]   out_col_r;
  logic [conv3_pkg::ROW_W-1:0]       out_row_r;
  logic                              out_last_r;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign s1_adv    = s1_valid_r && (!s1_pos_r.emit || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign load_out  = s1_adv && s1_pos_r.emit;

  conv3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .mode      (mode),
    .pos       (pos)
  );

  // word holds the row two back in the upper byte and the row one back in the lower byte
  conv3_ram #(
    .WIDTH (conv3_pkg::WORD_W),
    .DEPTH (conv3_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos_r.col),
    .wdata ({rd_word[conv3_pkg::PIX_W-1:0], s1_px_r}),
    .re    (in_accept),
    .raddr (pos.col),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos_r <= pos;
      s1_px_r  <= in_pixel_in;
    end
  end

  conv3_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (s1_adv),
    .top   (rd_word[conv3_pkg::WORD_W-1:conv3_pkg::PIX_W]),
    .mid   (rd_word[conv3_pkg::PIX_W-1:0]),
    .px    (s1_px_r),
    .mode  (mode),
    .value (value)
  );

  assign cm1 = s1_pos_r.col - conv3_pkg::COL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel_r <= value;
      out_col_r   <= conv3_pkg::OUT_COL_W'(cm1);
      out_row_r   <= s1_pos_r.row - conv3_pkg::ROW_W'(1);
      out_last_r  <= s1_pos_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = out_pixel_r;
  assign out_centre_col    = out_col_r;
  assign out_centre_row    = out_row_r;
  assign out_last_of_image = out_last_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && in_accept |-> s1_pos_r.col != pos.col)
    else $error("line store read and write hit the same column");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_pos_r) && $stable(s1_px_r))
    else $error("stalled item lost in window stage");

  a_interior_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_col_r != '0)
    else $error("result issued for a border column");

endmodule

FILE: tb/conv3x3_smooth_sharpen_filter_tb.sv
module conv3x3_smooth_sharpen_filter_tb;

  localparam logic [conv3_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_PCT = 36;
  localparam int RANDOM_ITEMS = 380;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    conv3_pkg::pix_t                 value;
    logic [conv3_pkg::OUT_COL_W-1:0] col;
    logic [conv3_pkg::ROW_W-1:0]     row;
    logic                            last;
  } filt_res_t;

  // one image row of three equal pixels
  typedef struct packed {
    conv3_pkg::mode_t mode;
    conv3_pkg::pix_t  pix;
    logic             typed;
    conv3_pkg::pix_t  want;
  } img_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  conv3_pkg::pix_t                  in_pixel_in = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [7:0]                       out_pixel_out;
  logic [10:0]                      out_centre_col;
  logic [15:0]                      out_centre_row;
  logic                             out_last_of_image;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  conv3x3_smooth_sharpen_filter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_in       (in_pixel_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_out     (out_pixel_out),
    .out_centre_col    (out_centre_col),
    .out_centre_row    (out_centre_row),
    .out_last_of_image (out_last_of_image),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // filter state mirror
  conv3_pkg::pix_t              older_line [conv3_pkg::MAX_WIDTH];
  conv3_pkg::pix_t              prev_line [conv3_pkg::MAX_WIDTH];
  conv3_pkg::pix_t              win [9];
  logic [conv3_pkg::COL_W-1:0]  next_col;
  logic [conv3_pkg::ROW_W-1:0]  next_row;
  conv3_pkg::mode_t             cur_mode;
  logic [conv3_pkg::WREG_W-1:0] width_reg;
  logic [conv3_pkg::ROW_W-1:0]  height_reg;

  filt_res_t expected_pixels [$];
  img_row_t  directed_rows [8];
  int        mismatch_count = 0;
  bit        calm = 1'b0;

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic bit predict_filtered_pixel(input conv3_pkg::pix_t px);
    int              w, h, c, r, acc, k;
    conv3_pkg::pix_t up, mid;
    filt_res_t       res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > conv3_pkg::MAX_WIDTH) w = conv3_pkg::MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    c = next_col;
    r = next_row;
    up = older_line[c];
    mid = prev_line[c];
    older_line[c] = mid;
    prev_line[c] = px;
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    predict_filtered_pixel = 1'b0;
    if (r >= 2 && c >= 2) begin
      if (cur_mode == conv3_pkg::MODE_MEAN) begin
        acc = 0;
        for (k = 0; k < 9; k++) acc += int'(win[k]);
        acc = acc / 9;
      end else begin
        acc = 5 * int'(win[4]) - int'(win[1]) - int'(win[3]) - int'(win[5]) - int'(win[7]);
        if (acc < 0) acc = 0;
        if (acc > conv3_pkg::PIX_MAX) acc = conv3_pkg::PIX_MAX;
      end
      res.value = conv3_pkg::pix_t'(acc);
      res.col = conv3_pkg::OUT_COL_W'(c - 1);
      res.row = conv3_pkg::ROW_W'(r - 1);
      res.last = (c >= w - 1) && (r >= h - 1);
      expected_pixels.push_back(res);
      predict_filtered_pixel = 1'b1;
    end
    if (c >= w - 1) begin
      next_col = '0;
      next_row = (r >= h - 1) ? '0 : conv3_pkg::ROW_W'(r + 1);
    end else begin
      next_col = conv3_pkg::COL_W'(c + 1);
    end
  endfunction

  task automatic push_pixel(input conv3_pkg::pix_t p, output bit made);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = predict_filtered_pixel(p);
  endtask

  function automatic conv3_pkg::pix_t draw_pixel(input bit extremes);
    if (extremes) begin
      draw_pixel = $urandom_range(1) ? conv3_pkg::pix_t'(conv3_pkg::PIX_MAX)
                                     : conv3_pkg::pix_t'(0);
    end else begin
      draw_pixel = conv3_pkg::pix_t'($urandom);
    end
  endfunction

  task automatic push_random(input int count, input bit extremes);
    bit made;
    repeat (count) push_pixel(draw_pixel(extremes), made);
  endtask

  // runs on to the wrap back to row 0, column 0
  task automatic finish_image(input bit extremes, output int fed);
    bit made;
    fed = 0;
    do begin
      push_pixel(draw_pixel(extremes), made);
      fed++;
    end while (next_col != 0 || next_row != 0);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [conv3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [conv3_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      conv3_pkg::CFG_MODE:   cur_mode = conv3_pkg::mode_t'(data[0]);
      conv3_pkg::CFG_WIDTH:  width_reg = data[conv3_pkg::WREG_W-1:0];
      conv3_pkg::CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    filt_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: pixel %0d col %0d row %0d last %0b",
                   out_pixel_out, out_centre_col, out_centre_row, out_last_of_image);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_out !== want.value || out_centre_col !== want.col ||
            out_centre_row !== want.row || out_last_of_image !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp pixel %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                     want.value, want.col, want.row, want.last,
                     out_pixel_out, out_centre_col, out_centre_row, out_last_of_image);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("conv3x3_smooth_sharpen_filter_tb NOT OK");
    $finish;
  end

  initial begin
    int  fed, done_items, n;
    bit  made, ext;
    logic [conv3_pkg::WREG_W-1:0] w_raw;
    logic [conv3_pkg::ROW_W-1:0]  h_raw;
    img_row_t rw;

    // width 3, height 8; mean rows first, then sharpen, typed values where obvious
    directed_rows = '{
      '{conv3_pkg::MODE_MEAN,  8'd255, 1'b0, 8'd0},
      '{conv3_pkg::MODE_MEAN,  8'd255, 1'b0, 8'd0},
      '{conv3_pkg::MODE_MEAN,  8'd255, 1'b1, 8'd255},
      '{conv3_pkg::MODE_MEAN,  8'd0,   1'b0, 8'd0},
      '{conv3_pkg::MODE_MEAN,  8'd0,   1'b0, 8'd0},
      '{conv3_pkg::MODE_MEAN,  8'd0,   1'b1, 8'd0},
      '{conv3_pkg::MODE_SHARP, 8'd255, 1'b1, 8'd0},
      '{conv3_pkg::MODE_SHARP, 8'd0,   1'b1, 8'd255}
    };
    for (n = 0; n < 9; n++) win[n] = '0;
    next_col = '0;
    next_row = '0;
    cur_mode = conv3_pkg::MODE_MEAN;
    width_reg = conv3_pkg::WREG_W'(conv3_pkg::MAX_WIDTH);
    height_reg = conv3_pkg::ROW_W'(2048);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(conv3_pkg::CFG_WIDTH, 16'd3);
    write_reg(conv3_pkg::CFG_HEIGHT, 16'd8);
    foreach (directed_rows[i]) begin
      rw = directed_rows[i];
      if (rw.mode != cur_mode) begin
        settle();
        write_reg(conv3_pkg::CFG_MODE, conv3_pkg::CFG_DATA_W'(rw.mode));
      end
      repeat (3) push_pixel(rw.pix, made);
      if (rw.typed && made) expected_pixels[expected_pixels.size()-1].value = rw.want;
    end

    // height cut short in the middle of a tall image
    settle();
    write_reg(conv3_pkg::CFG_HEIGHT, 16'hFFFF);
    push_random(12, 1'b0);
    settle();
    write_reg(conv3_pkg::CFG_HEIGHT, 16'd3);
    finish_image(1'b0, fed);

    // width cut short in the middle of a row
    settle();
    write_reg(conv3_pkg::CFG_WIDTH, 16'd8);
    write_reg(conv3_pkg::CFG_HEIGHT, 16'd5);
    push_random(21, 1'b0);
    settle();
    write_reg(conv3_pkg::CFG_WIDTH, 16'd4);
    finish_image(1'b0, fed);

    settle();
    write_reg(CFG_SPARE, conv3_pkg::CFG_DATA_W'($urandom));

    // full width, once exact and once clamped from above, cut short in the first row
    for (n = 0; n < 2; n++) begin
      settle();
      write_reg(conv3_pkg::CFG_MODE, conv3_pkg::CFG_DATA_W'($urandom));
      w_raw = (n == 0) ? conv3_pkg::WREG_W'(conv3_pkg::MAX_WIDTH)
                       : conv3_pkg::WREG_W'($urandom_range(4095, conv3_pkg::MAX_WIDTH + 1));
      write_reg(conv3_pkg::CFG_WIDTH, {4'($urandom), w_raw});
      write_reg(conv3_pkg::CFG_HEIGHT, conv3_pkg::CFG_DATA_W'($urandom_range(3)));
      push_random(40, 1'b0);
      settle();
      write_reg(conv3_pkg::CFG_WIDTH, 16'd5);
      finish_image(1'b0, fed);
    end

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      settle();
      calm = (done_items >= 250 && done_items < 350);
      w_raw = ($urandom_range(9) == 0) ? conv3_pkg::WREG_W'($urandom_range(2))
                                       : conv3_pkg::WREG_W'($urandom_range(10, 3));
      h_raw = ($urandom_range(9) == 0) ? conv3_pkg::ROW_W'($urandom_range(2))
                                       : conv3_pkg::ROW_W'($urandom_range(6, 3));
      write_reg(conv3_pkg::CFG_MODE, conv3_pkg::CFG_DATA_W'($urandom));
      write_reg(conv3_pkg::CFG_WIDTH, {4'($urandom), w_raw});
      write_reg(conv3_pkg::CFG_HEIGHT, h_raw);
      ext = ($urandom_range(3) == 0);
      finish_image(ext, fed);
      done_items += fed;
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("conv3x3_smooth_sharpen_filter_tb OK");
    end else begin
      $display("conv3x3_smooth_sharpen_filter_tb NOT OK");
    end
    $finish;
  end

endmodule
